FILE: rtl/wbc_pkg.sv
package wbc_pkg;

  // Default geometry of the classifier.
  localparam int DEF_BITS    = 6;
  localparam int DEF_PER_BIT = 10;
  localparam int DEF_DEPTH   = 70;

  // Field widths.
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 10;
  localparam int SPEED_W    = 8;
  localparam int LEN_W      = 24;
  localparam int LEVEL_W    = 10;
  localparam int SUM_W      = 24;
  localparam int CODE_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Command queue depth and quotient bits retired per divider cycle.
  localparam int Q_DEPTH   = 2;
  localparam int DIV_STEPS = 2;

  localparam logic [LEVEL_W-1:0] DARK_RESET = 10'd700;
  localparam logic [LEVEL_W-1:0] GRAY_RESET = 10'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRACK_LENGTH   = 2'd0,
    REG_DARK_THRESHOLD = 2'd1,
    REG_GRAY_LOW       = 2'd2
  } reg_idx_t;

  // One command from the front part to the back part.
  typedef struct packed {
    logic                due;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    FR_IDLE,
    FR_DIV
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_READ,
    BK_WAIT,
    BK_DONE
  } back_state_t;

endpackage

FILE: rtl/wbc_front.sv
module wbc_front #(
  parameter int DEPTH = wbc_pkg::DEF_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wbc_pkg::TIME_W-1:0]    now_ms,
  input  logic [wbc_pkg::SAMPLE_W-1:0]  sensor_value,
  input  logic [wbc_pkg::SPEED_W-1:0]   avg_speed,
  input  logic [wbc_pkg::LEN_W-1:0]     track_length,
  input  wbc_pkg::q_status_t            q_status,
  output logic                          q_push,
  output wbc_pkg::cmd_t                 q_data
);
  import wbc_pkg::*;

  localparam int DIVR_W  = $clog2((DEPTH - 1) * (2 ** SPEED_W - 1) + 1);
  localparam int DIV_CYC = (LEN_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int CNT_W   = $clog2(DIV_CYC + 1);
  localparam logic [DIVR_W-1:0] DEPTH_M1 = DIVR_W'(DEPTH - 1);

  front_state_t       state, state_next;
  logic [TIME_W-1:0]  next_time, time_next;
  logic               time_load;
  logic [TIME_W-1:0]  now_lat;
  logic [LEN_W-1:0]   quot, quot_w;
  logic [DIVR_W-1:0]  rem, rem_w;
  logic [DIVR_W-1:0]  divisor, speed_div;
  logic [DIVR_W:0]    trial;
  logic [CNT_W-1:0]   div_cnt;
  logic               accept;
  logic               due;

  assign in_stall  = (state != FR_IDLE) || q_status.full;
  assign accept    = in_valid && !in_stall;
  assign due       = now_ms >= next_time;
  assign speed_div = DEPTH_M1 * DIVR_W'(avg_speed);

  // Every accepted item becomes a command; the back part needs no quotient.
  assign q_push = accept;
  assign q_data = '{due: due, sample: sensor_value};

  // Restoring division, a few quotient bits per cycle.
  always_comb begin
    rem_w  = rem;
    quot_w = quot;
    trial  = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial  = {rem_w, quot_w[LEN_W-1]};
      quot_w = quot_w << 1;
      if (trial >= {1'b0, divisor}) begin
        trial     = trial - {1'b0, divisor};
        quot_w[0] = 1'b1;
      end
      rem_w = trial[DIVR_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    time_load  = 1'b0;
    time_next  = next_time;
    unique case (state)
      FR_IDLE: begin
        if (accept && due) begin
          if (avg_speed == '0) begin
            time_load = 1'b1;
            time_next = now_ms;
          end else begin
            state_next = FR_DIV;
          end
        end
      end
      FR_DIV: begin
        if (div_cnt == CNT_W'(DIV_CYC - 1)) begin
          state_next = FR_IDLE;
          time_load  = 1'b1;
          time_next  = now_lat + TIME_W'(quot_w);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FR_IDLE;
      next_time <= '0;
    end else begin
      state <= state_next;
      if (time_load) begin
        next_time <= time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && due) begin
      now_lat <= now_ms;
      quot    <= track_length;
      rem     <= '0;
      divisor <= speed_div;
      div_cnt <= '0;
    end else if (state == FR_DIV) begin
      quot    <= quot_w;
      rem     <= rem_w;
      div_cnt <= div_cnt + 1'b1;
    end
  end

endmodule

FILE: rtl/wbc_fifo.sv
module wbc_fifo #(
  parameter int DEPTH = wbc_pkg::Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wbc_pkg::cmd_t      data_in,
  input  logic               pop,
  output wbc_pkg::cmd_t      data_out,
  output wbc_pkg::q_status_t status
);
  import wbc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign data_out     = slots[rd_ptr];
  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

endmodule

FILE: rtl/wbc_ram.sv
module wbc_ram #(
  parameter int WIDTH = wbc_pkg::SUM_W,
  parameter int DEPTH = wbc_pkg::DEF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/wbc_back.sv
module wbc_back #(
  parameter int BITS    = wbc_pkg::DEF_BITS,
  parameter int PER_BIT = wbc_pkg::DEF_PER_BIT,
  parameter int DEPTH   = wbc_pkg::DEF_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wbc_pkg::q_status_t           q_status,
  output logic                         q_pop,
  input  wbc_pkg::cmd_t                q_data,
  input  logic [wbc_pkg::LEVEL_W-1:0]  dark_threshold,
  input  logic [wbc_pkg::LEVEL_W-1:0]  gray_low,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         code_valid,
  output logic [wbc_pkg::CODE_W-1:0]   code_bits
);
  import wbc_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WBW   = $clog2(BITS * PER_BIT + 1);
  localparam int LW    = (WBW > AW) ? WBW : AW;
  localparam int WCW   = $clog2(BITS + 1);
  localparam int KW    = $clog2(PER_BIT);
  localparam int THR_W = LEVEL_W + 1 + KW;
  localparam logic [KW-1:0] K       = KW'(PER_BIT - 1);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [CW:0]   DEPTH_C = (CW + 1)'(DEPTH);

  back_state_t          state, state_next;
  logic                 ram_we, issue, load_out, slot_free;
  logic [SAMPLE_W-1:0]  sample;
  logic [AW-1:0]        head, head_inc;
  logic [CW-1:0]        wr_cnt;
  logic [SUM_W-1:0]     newest, new_sum;
  logic [WBW-1:0]       win_base;
  logic                 iss_phase;
  logic [WCW-1:0]       iss_win, win_done;
  logic                 rd_v, rd_phase, rd_zero;
  logic [SUM_W-1:0]     rdata, rd_val, s_val, diff;
  logic [LW-1:0]        lidx;
  logic [AW-1:0]        cidx, raddr;
  logic [AW:0]          psum;
  logic [CW:0]          zsum;
  logic                 unwritten;
  logic [THR_W-1:0]     thr_dark, thr_gray;
  logic                 is_dark, is_gray, win_bit, win_ok;
  logic [BITS-1:0]      code, code_next, top_bit;
  logic [CODE_W-1:0]    code_out;
  logic                 ok;

  wbc_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head),
    .wdata(new_sum),
    .raddr(raddr),
    .rdata(rdata)
  );

  // The store is a ring: head is the oldest entry.
  assign new_sum  = newest + SUM_W'(sample);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  // Window index, clamped to the newest entry, then mapped onto the ring.
  assign lidx  = iss_phase ? (LW'(win_base) + LW'(PER_BIT - 1)) : LW'(win_base);
  assign cidx  = (lidx > LW'(DEPTH - 1)) ? AW'(DEPTH - 1) : lidx[AW-1:0];
  assign psum  = {1'b0, head} + {1'b0, cidx};
  assign raddr = (psum >= DEPTH_X) ? AW'(psum - DEPTH_X) : psum[AW-1:0];

  // Entries older than the fill count were never written and read as zero.
  assign zsum      = (CW + 1)'(cidx) + (CW + 1)'(wr_cnt);
  assign unwritten = zsum < DEPTH_C;

  // floor(diff / K) > dark is diff >= (dark + 1) * K; gray likewise.
  assign thr_dark = THR_W'({1'b0, dark_threshold} + 11'd1) * THR_W'(K);
  assign thr_gray = THR_W'(gray_low) * THR_W'(K);

  assign rd_val  = rd_zero ? '0 : rdata;
  assign diff    = rd_val - s_val;
  assign is_dark = diff >= SUM_W'(thr_dark);
  assign is_gray = diff >= SUM_W'(thr_gray);
  assign win_bit = !is_dark;
  assign win_ok  = is_dark || is_gray;

  always_comb begin
    top_bit         = '0;
    top_bit[BITS-1] = win_bit;
    code_next       = (code >> 1) | top_bit;
  end

  for (genvar j = 0; j < CODE_W; j++) begin : g_code
    if (j < BITS) begin : g_bit
      assign code_out[j] = code[j];
    end else begin : g_zero
      assign code_out[j] = 1'b0;
    end
  end

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop      = 1'b1;
          state_next = q_data.due ? BK_WRITE : BK_DONE;
        end
      end
      BK_WRITE: begin
        ram_we     = 1'b1;
        state_next = BK_READ;
      end
      BK_READ: begin
        issue = 1'b1;
        if (iss_phase && (iss_win == WCW'(BITS - 1))) begin
          state_next = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (win_done == WCW'(BITS)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      head      <= '0;
      wr_cnt    <= '0;
      newest    <= '0;
      out_valid <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
      if (ram_we) begin
        newest <= new_sum;
        head   <= head_inc;
        if (wr_cnt != CW'(DEPTH)) begin
          wr_cnt <= wr_cnt + 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample    <= q_data.sample;
      win_base  <= '0;
      iss_phase <= 1'b0;
      iss_win   <= '0;
      win_done  <= '0;
      code      <= '0;
      ok        <= q_data.due;
    end
    if (issue) begin
      iss_phase <= !iss_phase;
      if (iss_phase) begin
        win_base <= win_base + WBW'(PER_BIT);
        iss_win  <= iss_win + 1'b1;
      end
    end
    rd_phase <= iss_phase;
    rd_zero  <= unwritten;
    if (rd_v) begin
      if (!rd_phase) begin
        s_val <= rd_val;
      end else begin
        code     <= code_next;
        ok       <= ok && win_ok;
        win_done <= win_done + 1'b1;
      end
    end
    if (load_out) begin
      code_valid <= ok;
      code_bits  <= ok ? code_out : '0;
    end
  end

endmodule

FILE: rtl/windowed_barcode_classifier_core.sv
// Windowed barcode classifier.
// Input channel (in_valid/in_stall) carries now_ms, sensor_value and avg_speed;
// a transfer happens on a rising edge with in_valid high and in_stall low.
// Every input transfer yields exactly one output transfer (out_valid/out_stall)
// of code_valid and code_bits, in order.
// The front part compares the time against the next sample time and, for a
// due item with nonzero speed, runs a restoring divider that retires two
// quotient bits per cycle: the input is held off while the divider runs after
// such a transfer, otherwise the front takes one item per cycle while the
// two-entry command queue has room.
// The back part works one command at a time. An item that is not due
// goes from the queue to the output register without touching the store.
// A due item passes through the back part in order: taking the command, one
// store write, one read per window edge through the single read port, a drain
// of the read pipeline and loading the output; no new command is taken before that.
// Reset clears the configuration to its defaults, the next sample time, the
// queue and the output register; the store needs no clearing pass, since a
// fill count makes never-written entries read as zero.
// While out_stall is high the result is held and the back part waits, while the queue
// keeps the front taking items until it fills. Configuration writes belong to idle periods.
module windowed_barcode_classifier_core #(
  parameter int BITS    = wbc_pkg::DEF_BITS,
  parameter int PER_BIT = wbc_pkg::DEF_PER_BIT,
  parameter int DEPTH   = wbc_pkg::DEF_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wbc_pkg::TIME_W-1:0]     now_ms,
  input  logic [wbc_pkg::SAMPLE_W-1:0]   sensor_value,
  input  logic [wbc_pkg::SPEED_W-1:0]    avg_speed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           code_valid,
  output logic [wbc_pkg::CODE_W-1:0]     code_bits
);
  import wbc_pkg::*;

  // Configuration registers.
  logic [LEN_W-1:0]   track_length;
  logic [LEVEL_W-1:0] dark_threshold;
  logic [LEVEL_W-1:0] gray_low;

  // Command queue between the front and back parts.
  logic      q_push, q_pop;
  cmd_t      q_in, q_out;
  q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_length   <= '0;
      dark_threshold <= DARK_RESET;
      gray_low       <= GRAY_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TRACK_LENGTH:   track_length   <= cfg_data[LEN_W-1:0];
        REG_DARK_THRESHOLD: dark_threshold <= cfg_data[LEVEL_W-1:0];
        REG_GRAY_LOW:       gray_low       <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // The front part decides whether an item is due and keeps the sample clock.
  wbc_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .now_ms      (now_ms),
    .sensor_value(sensor_value),
    .avg_speed   (avg_speed),
    .track_length(track_length),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  wbc_fifo #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .data_in (q_in),
    .pop     (q_pop),
    .data_out(q_out),
    .status  (q_status)
  );

  // The back part updates the prefix store and classifies the windows.
  wbc_back #(
    .BITS   (BITS),
    .PER_BIT(PER_BIT),
    .DEPTH  (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .q_data        (q_out),
    .dark_threshold(dark_threshold),
    .gray_low      (gray_low),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_valid    (code_valid),
    .code_bits     (code_bits)
  );

  // The front part must never push into a full queue.
  a_queue_no_overflow: assert property (
    @(posedge clk) disable iff (rst) q_status.full |-> !q_push
  ) else $error("command queue overflow");

  // The back part must never pop an empty queue.
  a_queue_no_underflow: assert property (
    @(posedge clk) disable iff (rst) q_status.empty |-> !q_pop
  ) else $error("command queue underflow");

  // An invalid code always carries zero bits.
  a_invalid_code_zero: assert property (
    @(posedge clk) disable iff (rst) (out_valid && !code_valid) |-> (code_bits == '0)
  ) else $error("invalid code with nonzero bits");

endmodule

FILE: verif/windowed_barcode_classifier_core_test.sv
module windowed_barcode_classifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbc_pkg::*;

  // Geometry of the instance under test, taken from the package defaults.
  localparam int BITS    = DEF_BITS;
  localparam int PER_BIT = DEF_PER_BIT;
  localparam int DEPTH   = DEF_DEPTH;

  // Cycles allowed after the last result before the block counts as idle. A due
  // item costs the divider hold-off plus the back part's pass over the store.
  localparam int SETTLE_CYCLES = 2 * BITS + 30;

  // One decoded result as the block reports it.
  typedef struct packed {
    logic              code_valid;
    logic [CODE_W-1:0] code_bits;
  } decoded_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     now_ms = '0;
  logic [SAMPLE_W-1:0]   sensor_value = '0;
  logic [SPEED_W-1:0]    avg_speed = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  code_valid;
  logic [CODE_W-1:0]     code_bits;

  // When set, neither channel idles: the sender has no gaps and the receiver
  // never stalls.
  bit steady = 1'b0;

  // Shadow of the configuration registers and of the block's state, kept in
  // step with every transfer the block accepts.
  logic [LEN_W-1:0]   track_len_cfg = '0;
  logic [LEVEL_W-1:0] dark_cfg = DARK_RESET;
  logic [LEVEL_W-1:0] gray_cfg = GRAY_RESET;
  logic [TIME_W-1:0]  next_sample_ms = '0;
  logic [SUM_W-1:0]   prefix_sums [DEPTH] = '{default: '0};

  // Results predicted for accepted readings, oldest first.
  decoded_t pending_codes [$];

  int unsigned error_count = 0;
  int unsigned readings_sent = 0;
  int unsigned due_readings = 0;
  int unsigned decodes_expected = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;

  windowed_barcode_classifier_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .sensor_value (sensor_value),
    .avg_speed    (avg_speed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_valid   (code_valid),
    .code_bits    (code_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out what one reading produces and advances the shadow state. A
  // reading that is not yet due leaves everything untouched and yields an
  // invalid code. A due reading moves the next sample time, pushes a new
  // running sum into the store and then classifies the windows, oldest first.
  function automatic decoded_t classify_reading(input logic [TIME_W-1:0] t,
                                                input logic [SAMPLE_W-1:0] sample,
                                                input logic [SPEED_W-1:0] speed);
    decoded_t result;
    logic [TIME_W-1:0] interval;
    logic [SUM_W-1:0] span;
    logic [31:0] window_avg;
    int first_idx;
    int last_idx;
    result = '0;
    if (t < next_sample_ms) return result;

    // Zero speed means sample on every call, so the interval collapses to 0.
    interval = (speed == 0) ? '0
             : TIME_W'(32'(track_len_cfg) / (32'(DEPTH - 1) * 32'(speed)));
    next_sample_ms = t + interval;

    // After the shift the last entry still holds the old newest sum, so adding
    // the sample in place gives the new running sum modulo 2^24.
    for (int i = 0; i < DEPTH - 1; i++) prefix_sums[i] = prefix_sums[i + 1];
    prefix_sums[DEPTH - 1] = prefix_sums[DEPTH - 1] + SUM_W'(sample);

    result.code_valid = 1'b1;
    for (int b = 0; b < BITS; b++) begin
      // Windows that would run past the store read its newest entry.
      first_idx = (PER_BIT * b > DEPTH - 1) ? DEPTH - 1 : PER_BIT * b;
      last_idx = (PER_BIT * (b + 1) - 1 > DEPTH - 1) ? DEPTH - 1 : PER_BIT * (b + 1) - 1;
      span = prefix_sums[last_idx] - prefix_sums[first_idx];
      window_avg = 32'(span) / (PER_BIT - 1);
      if (window_avg > dark_cfg) begin
        // Black window: the bit stays clear.
      end else if (window_avg >= gray_cfg) begin
        if (b < CODE_W) result.code_bits[b] = 1'b1;
      end else begin
        // Neither black nor gray: the whole code is thrown away.
        result.code_valid = 1'b0;
        break;
      end
    end
    if (!result.code_valid) result.code_bits = '0;
    return result;
  endfunction

  // Chooses a time relative to the next sample time: mostly at or just past
  // it, otherwise a few milliseconds short so the reading is not due.
  function automatic logic [TIME_W-1:0] pick_time(input int due_pct);
    if ($urandom_range(0, 99) < due_pct || next_sample_ms < 4)
      return next_sample_ms + $urandom_range(0, 3);
    return next_sample_ms - 1 - $urandom_range(0, 2);
  endfunction

  // A sample that belongs to a black or a gray bar under the current levels,
  // with the odd smudge that may spoil a window.
  function automatic logic [SAMPLE_W-1:0] bar_level(input logic is_gray);
    if ($urandom_range(0, 99) < 3) return SAMPLE_W'($urandom_range(0, 1000));
    if (is_gray) return SAMPLE_W'($urandom_range(gray_cfg, dark_cfg));
    return SAMPLE_W'($urandom_range(dark_cfg + 1, 1000));
  endfunction

  // Offers one reading, holds it until the block takes it and then records
  // the result it must produce. Valid is raised again right away for the next
  // reading unless a random gap lowers it first.
  task automatic send_reading(input logic [TIME_W-1:0] t,
                              input logic [SAMPLE_W-1:0] sample,
                              input logic [SPEED_W-1:0] speed);
    decoded_t want;
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    now_ms       <= t;
    sensor_value <= sample;
    avg_speed    <= speed;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (t >= next_sample_ms) due_readings++;
    want = classify_reading(t, sample, speed);
    if (want.code_valid) decodes_expected++;
    pending_codes.push_back(want);
    readings_sent++;
  endtask

  // Stops sending and waits until every predicted result has been seen, then
  // gives the block time to finish whatever it still has in hand.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TRACK_LENGTH:   track_len_cfg = value[LEN_W-1:0];
      REG_DARK_THRESHOLD: dark_cfg = value[LEVEL_W-1:0];
      REG_GRAY_LOW:       gray_cfg = value[LEVEL_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(input logic [LEN_W-1:0] track_len,
                           input logic [LEVEL_W-1:0] dark,
                           input logic [LEVEL_W-1:0] gray);
    write_reg(REG_TRACK_LENGTH, CFG_DATA_W'(track_len));
    write_reg(REG_DARK_THRESHOLD, CFG_DATA_W'(dark));
    write_reg(REG_GRAY_LOW, CFG_DATA_W'(gray));
  endtask

  // Hand-picked readings: the empty store, the time extremes, readings one
  // millisecond short of due and exactly due, the interval wrapping past
  // 2^32, zero and full speed, black and gray windows, and gray bounds that
  // are turned upside down so nothing can be gray.
  task automatic test_directed_cases();
    // With the store still at reset every window averages zero, below gray.
    send_reading('0, 10'd1000, 8'd0);
    write_reg(REG_GRAY_LOW, 24'd0);
    write_reg(REG_DARK_THRESHOLD, 24'd1023);
    send_reading('1, 10'd0, 8'hFF);
    send_reading(32'd5, 10'd1000, 8'd1);
    write_reg(REG_TRACK_LENGTH, 24'hFF_FFFF);
    // The longest interval pushes the next sample time past the top of the
    // time range, so it wraps to a small value.
    send_reading('1, 10'd512, 8'd1);
    send_reading(next_sample_ms - 1, 10'd1000, 8'd0);
    send_reading(next_sample_ms, 10'd1000, 8'd0);
    // With both levels at zero an empty window is gray and any other is black;
    // twelve full-scale samples make the newest window turn black.
    write_reg(REG_DARK_THRESHOLD, 24'd0);
    for (int i = 0; i < 12; i++) send_reading(next_sample_ms + i, 10'd1000, 8'd0);
    write_reg(REG_GRAY_LOW, 24'd1023);
    send_reading(next_sample_ms, 10'd1000, 8'd0);
    send_reading(next_sample_ms, 10'd0, 8'd0);
  endtask

  // Whole barcodes: ten samples per bar, black or gray by a random pattern,
  // with most readings due. The first barcode runs with no idling at all.
  task automatic test_barcodes();
    logic [CODE_W-1:0] pattern;
    configure(24'd40000, DARK_RESET, GRAY_RESET);
    steady = 1'b1;
    for (int n = 0; n < 6; n++) begin
      if (n == 1) steady = 1'b0;
      if (n == 3) configure(24'd120000, 10'd850, 10'd150);
      pattern = CODE_W'($urandom());
      for (int w = 0; w < BITS; w++)
        for (int k = 0; k < PER_BIT; k++)
          send_reading(pick_time(85), bar_level(pattern[w % CODE_W]), SPEED_W'($urandom()));
    end
  endtask

  // Bars of random level with some jitter under several level settings,
  // including all-gray, nothing-gray and fully random ones.
  task automatic test_threshold_sweep();
    int level;
    int sample;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: configure('0, DARK_RESET, GRAY_RESET);
        1: configure(LEN_W'($urandom_range(0, 300000)), 10'd1023, 10'd0);
        2: configure(24'hFF_FFFF, 10'd0, 10'd1023);
        3: configure(LEN_W'($urandom_range(0, 300000)), 10'd0, 10'd0);
        default: configure(LEN_W'($urandom()), LEVEL_W'($urandom()), LEVEL_W'($urandom()));
      endcase
      for (int i = 0; i < 80; i++) begin
        if (i % PER_BIT == 0) level = $urandom_range(0, 1000);
        sample = level + int'($urandom_range(0, 40)) - 20;
        if (sample < 0) sample = 0;
        if (sample > 1000) sample = 1000;
        send_reading(pick_time(80), SAMPLE_W'(sample), SPEED_W'($urandom()));
      end
    end
  endtask

  // Unstructured readings: arbitrary times across the whole range, arbitrary
  // samples and speeds. Halfway through the sender holds back until every
  // outstanding result has been delivered.
  task automatic test_random_readings();
    logic [TIME_W-1:0] t;
    logic [SPEED_W-1:0] speed;
    configure(LEN_W'($urandom()), DARK_RESET, GRAY_RESET);
    for (int i = 0; i < 160; i++) begin
      if (i == 80) settle();
      t = ($urandom_range(0, 99) < 15) ? TIME_W'($urandom()) : pick_time(70);
      speed = ($urandom_range(0, 4) == 0) ? '0 : SPEED_W'($urandom());
      send_reading(t, SAMPLE_W'($urandom_range(0, 1000)), speed);
    end
  endtask

  // The receiver stalls at random except during steady stretches.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 25);
  end

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    decoded_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_codes.size() == 0) begin
        $error("result with no reading outstanding: code_valid %0b code_bits %0h",
               code_valid, code_bits);
        error_count++;
      end else begin
        want = pending_codes.pop_front();
        results_checked++;
        if (code_valid !== want.code_valid) begin
          $error("code_valid: expected %0b, got %0b", want.code_valid, code_valid);
          error_count++;
        end
        if (code_bits !== want.code_bits) begin
          $error("code_bits: expected %0h, got %0h", want.code_bits, code_bits);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_barcodes();
    test_threshold_sweep();
    test_random_readings();
    settle();
    $display("Covered %0d readings, %0d of them due and %0d expected to decode.",
             readings_sent, due_readings, decodes_expected);
    $display("Compared %0d results across %0d register writes with random stalls.",
             results_checked, reg_writes);
    if (error_count == 0) begin
      $display("windowed_barcode_classifier_core_test OK");
    end else begin
      $display("windowed_barcode_classifier_core_test NOT OK");
    end
    $finish;
  end

  // Backstop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("windowed_barcode_classifier_core_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/wbc_pkg.sv
rtl/wbc_front.sv
rtl/wbc_fifo.sv
rtl/wbc_ram.sv
rtl/wbc_back.sv
rtl/windowed_barcode_classifier_core.sv
verif/windowed_barcode_classifier_core_test.sv
